// ===== hw/rtl/sha2_message_padder_unit_assert.svh =====
// Assertion macros shared by the SHA-2 message padder RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SHA2_MESSAGE_PADDER_UNIT_ASSERT_SVH
`define SHA2_MESSAGE_PADDER_UNIT_ASSERT_SVH

// Check that a condition never holds outside reset.
`define SHA2MP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Check that a consequence holds in the cycle after an antecedent.
`define SHA2MP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sha2mp_pkg.sv =====
// Shared types and constants for the SHA-2 message padder.
// No dependencies; imported by the unit, pad and sequencer modules.
`timescale 1ns / 1ps

package sha2mp_pkg;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [7:0] SIZE_NARROW = 8'd64;
  localparam logic [7:0] SIZE_WIDE   = 8'd128;
  localparam logic [7:0] ROOM_NARROW = 8'd55;   // 64 - 8 - 1
  localparam logic [7:0] ROOM_WIDE   = 8'd111;  // 128 - 16 - 1
  localparam logic [3:0] LAST_WORD   = 4'hF;

  typedef enum logic [1:0] {
    MODE_SHA224,
    MODE_SHA256,
    MODE_SHA384,
    MODE_SHA512
  } hash_mode_t;

  // Content of one outgoing block
  typedef enum logic [2:0] {
    BLK_DATA_FULL,     // all stored bytes
    BLK_DATA_PAD,      // stored bytes, 0x80, zeros
    BLK_DATA_PAD_LEN,  // stored bytes, 0x80, zeros, length
    BLK_LEN_ONLY,      // zeros, length
    BLK_PAD_LEN        // 0x80, zeros, length
  } blk_kind_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_READ,
    SEQ_SEND
  } seq_state_t;

  typedef struct packed {
    logic       in_ready;
    logic       rd_en;
    logic       out_valid;
    logic [3:0] word;
    logic       blk_sel;
  } seq_ctl_t;

  function automatic logic kind_is_final(blk_kind_t kind);
    logic fin;
    unique case (kind)
      BLK_DATA_PAD_LEN, BLK_LEN_ONLY, BLK_PAD_LEN: fin = 1'b1;
      default:                                     fin = 1'b0;
    endcase
    return fin;
  endfunction

endpackage

// ===== hw/rtl/sha2_message_padder_unit.sv =====
// A byte that completes no block is taken while the sequencer idles, and it stays ready.
// A byte that fills a block, or the last byte, starts a run of 16 or 32 words; each word
// is read from the buffer (SEQ_READ) and then presented (SEQ_SEND), and the next read waits
// until the receiver takes the word. No byte is taken until the run ends.
// Reset clears the byte count, selects SHA-256 and idles the sequencer; the buffer is not
// cleared.
`timescale 1ns / 1ps

module sha2_message_padder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [31:0] word_high, [63:32] word_low
  output logic        out_tlast,   // block_end
  output logic [1:0]  out_tuser,   // [0] final_block, [1] run_end
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data  // hash_mode
);

  import sha2mp_pkg::*;

  `include "sha2_message_padder_unit_assert.svh"

  hash_mode_t hash_mode_r;
  logic [31:0] byte_cnt_r;
  blk_kind_t   kind0_r, kind1_r;
  logic        two_blk_r;
  logic        wide_r;
  logic [7:0]  fill_r;
  logic [31:0] bit_len_r;

  logic        wide_now;
  logic [6:0]  pos_now;
  logic [7:0]  fill_now;
  logic [7:0]  size_now;
  logic [7:0]  room_now;
  logic [31:0] cnt_inc;
  logic        in_acc;
  logic        out_acc;
  logic        emit_now;
  logic        two_now;
  blk_kind_t   k0_now, k1_now;
  blk_kind_t   kind_cur;
  seq_ctl_t    ctl;
  logic [4:0]  rd_addr_a;
  logic [4:0]  rd_addr_b;
  logic [31:0] rd_data_a;
  logic [31:0] rd_data_b;
  logic [31:0] word_high;
  logic [31:0] word_low;
  logic        block_end;
  logic        run_end;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Place the byte by the current block size
  assign wide_now = hash_mode_r[1];
  assign pos_now  = wide_now ? byte_cnt_r[6:0] : {1'b0, byte_cnt_r[5:0]};
  assign fill_now = {1'b0, pos_now} + 8'd1;
  assign size_now = wide_now ? SIZE_WIDE : SIZE_NARROW;
  assign room_now = wide_now ? ROOM_WIDE : ROOM_NARROW;
  assign cnt_inc  = byte_cnt_r + 32'd1;

  // Plan the blocks this byte releases
  always_comb begin
    emit_now = 1'b0;
    two_now  = 1'b0;
    k0_now   = BLK_DATA_FULL;
    k1_now   = BLK_PAD_LEN;
    priority if (in_tlast && (fill_now <= room_now)) begin
      emit_now = 1'b1;
      k0_now   = BLK_DATA_PAD_LEN;
    end else if (in_tlast && (fill_now < size_now)) begin
      emit_now = 1'b1;
      two_now  = 1'b1;
      k0_now   = BLK_DATA_PAD;
      k1_now   = BLK_LEN_ONLY;
    end else if (in_tlast) begin
      emit_now = 1'b1;
      two_now  = 1'b1;
    end else if (fill_now == size_now) begin
      emit_now = 1'b1;
    end else begin
      emit_now = 1'b0;
    end
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_mode_r <= MODE_SHA256;
    end else if (cfg_wr_en) begin
      hash_mode_r <= hash_mode_t'(cfg_wr_data);
    end
  end

  // Byte count, cleared after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= 32'd0;
    end else if (in_acc) begin
      byte_cnt_r <= in_tlast ? 32'd0 : cnt_inc;
    end
  end

  // Hold the run plan while words go out
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind0_r   <= k0_now;
      kind1_r   <= k1_now;
      two_blk_r <= two_now;
      wide_r    <= wide_now;
      fill_r    <= fill_now;
      bit_len_r <= {cnt_inc[28:0], 3'b000};
    end
  end

  sha2mp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && emit_now),
    .two_blk   (two_blk_r),
    .out_ready (out_tready),
    .ctl       (ctl)
  );

  assign rd_addr_a = wide_r ? {ctl.word, 1'b0} : {1'b0, ctl.word};
  assign rd_addr_b = wide_r ? {ctl.word, 1'b1} : {1'b0, ctl.word};

  sha2mp_buf u_buf (
    .clk       (clk),
    .wr_en     (in_acc),
    .wr_addr   (pos_now),
    .wr_data   (in_tdata),
    .rd_en     (ctl.rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign kind_cur = ctl.blk_sel ? kind1_r : kind0_r;

  sha2mp_pad u_pad (
    .wide      (wide_r),
    .kind      (kind_cur),
    .word      (ctl.word),
    .fill      (fill_r),
    .bit_len   (bit_len_r),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .word_high (word_high),
    .word_low  (word_low)
  );

  // Drive the result beat
  assign block_end  = (ctl.word == LAST_WORD);
  assign run_end    = block_end && (ctl.blk_sel || !two_blk_r);
  assign in_tready  = ctl.in_ready;
  assign out_tvalid = ctl.out_valid;
  assign out_tdata  = {word_low, word_high};
  assign out_tlast  = block_end;
  assign out_tuser  = {run_end, kind_is_final(kind_cur)};

  `SHA2MP_ASSERT_NEVER(a_no_overlap, in_tready && out_tvalid, "input taken during a run")
  `SHA2MP_ASSERT_NEXT(a_read_then_send, ctl.rd_en, out_tvalid, "read not followed by beat")
  `SHA2MP_ASSERT_NEXT(a_last_clears, in_acc && in_tlast, byte_cnt_r == 32'd0, "count kept")
  `SHA2MP_ASSERT_NEXT(a_run_end_idle, out_acc && run_end, in_tready, "no idle after run")

endmodule

// ===== hw/rtl/sha2mp_buf.sv =====
// Block byte buffer: 32 x 32-bit memory, byte-lane writes, two registered read ports.
// Depends on nothing but the clock.
`timescale 1ns / 1ps

module sha2mp_buf (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [6:0]  wr_addr,    // byte position within the block
  input  logic [7:0]  wr_data,
  input  logic        rd_en,
  input  logic [4:0]  rd_addr_a,
  input  logic [4:0]  rd_addr_b,
  output logic [31:0] rd_data_a,
  output logic [31:0] rd_data_b
);

  logic [31:0] mem_r [32];
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;

  // Write one byte lane of one word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int l = 0; l < 4; l++) begin
        if (wr_addr[1:0] == 2'(l)) begin
          mem_r[wr_addr[6:2]][8*l +: 8] <= wr_data;
        end
      end
    end
  end

  // Read two words, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem_r[rd_addr_a];
      rd_b_r <= mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== hw/rtl/sha2mp_pad.sv =====
// Padding unit: builds one output word from buffer data, the 0x80 marker and the length.
// Depends on sha2mp_pkg; reused for every word of every block.
`timescale 1ns / 1ps

module sha2mp_pad (
  input  logic                  wide,
  input  sha2mp_pkg::blk_kind_t kind,
  input  logic [3:0]            word,
  input  logic [7:0]            fill,       // bytes of data in the block
  input  logic [31:0]           bit_len,
  input  logic [31:0]           rd_data_a,
  input  logic [31:0]           rd_data_b,
  output logic [31:0]           word_high,
  output logic [31:0]           word_low
);

  import sha2mp_pkg::*;

  logic [7:0]       lim;
  logic             pad_en;
  logic [6:0]       pad_pos;
  logic             len_en;
  logic [63:0]      src_all;
  logic [63:0]      len_all;
  logic [6:0]       pos_s;
  logic [7:0][7:0]  bytes_v;

  // Decode the block kind
  always_comb begin
    lim     = 8'd0;
    pad_en  = 1'b0;
    pad_pos = 7'd0;
    len_en  = 1'b0;
    unique case (kind)
      BLK_DATA_FULL: begin
        lim = SIZE_WIDE;
      end
      BLK_DATA_PAD: begin
        lim     = fill;
        pad_en  = 1'b1;
        pad_pos = fill[6:0];
      end
      BLK_DATA_PAD_LEN: begin
        lim     = fill;
        pad_en  = 1'b1;
        pad_pos = fill[6:0];
        len_en  = 1'b1;
      end
      BLK_LEN_ONLY: begin
        len_en = 1'b1;
      end
      BLK_PAD_LEN: begin
        pad_en = 1'b1;
        len_en = 1'b1;
      end
      default: begin
        lim = 8'd0;
      end
    endcase
  end

  // Length sits big-endian in the last four bytes: lane 0 of the low half takes bits 31:24
  assign len_all = {bit_len[7:0], bit_len[15:8], bit_len[23:16], bit_len[31:24], 32'd0};
  assign src_all = {rd_data_b, rd_data_a};

  // Pick each byte slot: length, then marker, then data, else zero
  always_comb begin
    pos_s   = 7'd0;
    bytes_v = '0;
    for (int s = 0; s < 8; s++) begin
      if (wide) begin
        pos_s = {word, 3'(s)};
      end else begin
        pos_s = {1'b0, word, 2'(s)};
      end
      if (len_en && (word == LAST_WORD) && (s >= 4)) begin
        bytes_v[s] = len_all[8*s +: 8];
      end else if (pad_en && (pos_s == pad_pos)) begin
        bytes_v[s] = PAD_BYTE;
      end else if ({1'b0, pos_s} < lim) begin
        bytes_v[s] = src_all[8*s +: 8];
      end else begin
        bytes_v[s] = 8'd0;
      end
    end
  end

  assign word_high = wide ? bytes_v[3:0] : 32'd0;
  assign word_low  = bytes_v[7:4];

endmodule

// ===== hw/rtl/sha2mp_seq.sv =====
// Word sequencer: steps 16 words per block, one or two blocks per run.
// Depends on sha2mp_pkg.
`timescale 1ns / 1ps

module sha2mp_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 two_blk,
  input  logic                 out_ready,
  output sha2mp_pkg::seq_ctl_t ctl
);

  import sha2mp_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [3:0] word_r, word_nxt;
  logic       blk_r, blk_nxt;
  logic       run_done;

  assign run_done = (word_r == LAST_WORD) && (blk_r || !two_blk);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) state_nxt = SEQ_READ;
      end
      SEQ_READ: begin
        state_nxt = SEQ_SEND;
      end
      SEQ_SEND: begin
        if (out_ready) state_nxt = run_done ? SEQ_IDLE : SEQ_READ;
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  // Advance word and block counters
  always_comb begin
    word_nxt = word_r;
    blk_nxt  = blk_r;
    if ((state_r == SEQ_IDLE) && start) begin
      word_nxt = 4'd0;
      blk_nxt  = 1'b0;
    end else if ((state_r == SEQ_SEND) && out_ready) begin
      word_nxt = word_r + 4'd1;
      if (word_r == LAST_WORD) blk_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      word_r  <= 4'd0;
      blk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      word_r  <= word_nxt;
      blk_r   <= blk_nxt;
    end
  end

  // Outputs
  always_comb begin
    ctl.in_ready  = (state_r == SEQ_IDLE);
    ctl.rd_en     = (state_r == SEQ_READ);
    ctl.out_valid = (state_r == SEQ_SEND);
    ctl.word      = word_r;
    ctl.blk_sel   = blk_r;
  end

endmodule

// ===== tb/sha2_message_padder_unit_tb.sv =====
// Self-checking testbench for the SHA-2 message padder: byte stream in, hash-core words out.
// Depends on sha2mp_pkg and sha2_message_padder_unit; a class-based word predictor checks
// every output beat.
`timescale 1ns / 1ps

module sha2_message_padder_unit_tb;
  import sha2mp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  // One hash-core word as it should leave the block
  typedef struct {
    logic [31:0] hi;
    logic [31:0] lo;
    logic        fin;
    logic        blk_end;
    logic        run_end;
  } pad_word_t;

  // Predict the padded words of each message and check them in order
  class padder_book;
    hash_mode_t  mode;
    logic [7:0]  store[128];
    bit          written[128];
    logic [31:0] byte_count;
    pad_word_t   pending[$];
    int          errors;
    int          words_checked;
    int          messages;

    function new();
      mode = MODE_SHA256;
      byte_count = '0;
      errors = 0;
      words_checked = 0;
      messages = 0;
      foreach (written[k]) written[k] = 1'b0;
    endfunction

    function void set_mode(hash_mode_t m);
      mode = m;
    endfunction

    // True once every buffer entry holds a byte, so any mode switch reads defined data
    function bit store_full();
      foreach (written[k]) if (!written[k]) return 1'b0;
      return 1'b1;
    endfunction

    // Queue the 16 words of one block
    function void push_block(logic [7:0] b[128], bit wide, bit fin);
      pad_word_t w;
      for (int i = 0; i < 16; i++) begin
        if (wide) begin
          w.hi = {b[8*i+3], b[8*i+2], b[8*i+1], b[8*i]};
          w.lo = {b[8*i+7], b[8*i+6], b[8*i+5], b[8*i+4]};
        end else begin
          w.hi = '0;
          w.lo = {b[4*i+3], b[4*i+2], b[4*i+1], b[4*i]};
        end
        w.fin = fin;
        w.blk_end = (i == 15);
        w.run_end = 1'b0;
        pending.push_back(w);
      end
    endfunction

    // Store one accepted byte and queue the words it releases
    function void note_byte(logic [7:0] d, logic l);
      bit          wide;
      int unsigned blk_size;
      int unsigned room;
      int unsigned pos;
      int unsigned fill;
      int          n0;
      logic [31:0] bit_len;
      logic [7:0]  blk[128];
      wide = mode[1];
      blk_size = wide ? int'(SIZE_WIDE) : int'(SIZE_NARROW);
      room = wide ? int'(ROOM_WIDE) : int'(ROOM_NARROW);
      pos = byte_count % blk_size;
      n0 = pending.size();
      store[pos] = d;
      written[pos] = 1'b1;
      byte_count = byte_count + 1;
      fill = pos + 1;
      if (l) begin
        bit_len = byte_count << 3;
        for (int k = 0; k < 128; k++) blk[k] = (k < fill) ? store[k] : 8'h00;
        if (fill < blk_size) blk[fill] = PAD_BYTE;
        // Length does not fit: close the data block and start a padding block
        if (fill > room) begin
          push_block(blk, wide, 1'b0);
          for (int k = 0; k < 128; k++) blk[k] = 8'h00;
          if (fill == blk_size) blk[0] = PAD_BYTE;
        end
        blk[blk_size-4] = bit_len[31:24];
        blk[blk_size-3] = bit_len[23:16];
        blk[blk_size-2] = bit_len[15:8];
        blk[blk_size-1] = bit_len[7:0];
        push_block(blk, wide, 1'b1);
        byte_count = '0;
        messages++;
      end else if (fill == blk_size) begin
        for (int k = 0; k < 128; k++) blk[k] = store[k];
        push_block(blk, wide, 1'b0);
      end
      if (pending.size() > n0) pending[pending.size()-1].run_end = 1'b1;
    endfunction

    // Compare one output beat with the oldest predicted word
    function void check_word(logic [63:0] td, logic tl, logic [1:0] tu);
      pad_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected word: tdata %h tlast %b tuser %b", td, tl, tu);
        errors++;
        return;
      end
      w = pending.pop_front();
      words_checked++;
      if (td[31:0] !== w.hi) begin
        $error("word_high: expected %h, actual %h", w.hi, td[31:0]);
        errors++;
      end
      if (td[63:32] !== w.lo) begin
        $error("word_low: expected %h, actual %h", w.lo, td[63:32]);
        errors++;
      end
      if (tu[0] !== w.fin) begin
        $error("final_block: expected %b, actual %b", w.fin, tu[0]);
        errors++;
      end
      if (tl !== w.blk_end) begin
        $error("block_end: expected %b, actual %b", w.blk_end, tl);
        errors++;
      end
      if (tu[1] !== w.run_end) begin
        $error("run_end: expected %b, actual %b", w.run_end, tu[1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = MODE_SHA256;

  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          cycles = 0;
  padder_book  book = new();

  sha2_message_padder_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check each output beat and stall the receiver at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_word(out_tdata, out_tlast, out_tuser);
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sha2_message_padder_unit_tb failed");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles first, and hold it until accepted
  task automatic send_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    book.note_byte(d, l);
  endtask

  // Drop valid and wait for the block to drain all predicted words
  task automatic settle();
    in_tvalid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input hash_mode_t m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    book.set_mode(m);
  endtask

  // Favor lengths around the padding and block boundaries of the current mode
  function automatic int unsigned pick_length(hash_mode_t m);
    int unsigned blk_size;
    int unsigned room;
    blk_size = m[1] ? int'(SIZE_WIDE) : int'(SIZE_NARROW);
    room = m[1] ? int'(ROOM_WIDE) : int'(ROOM_NARROW);
    case ($urandom_range(9))
      0: return room + $urandom_range(1);
      1: return blk_size - 1 + $urandom_range(2);
      2: return $urandom_range(13, blk_size);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  initial begin
    int unsigned rand_bytes;
    int unsigned len;
    int unsigned split;
    rand_bytes = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme bytes, one-byte messages and every mode, starting at reset mode
    in_idle_pct = 16;
    out_idle_pct = 60;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    settle();
    write_mode(MODE_SHA512);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();
    write_mode(MODE_SHA224);
    send_byte(8'hA5, 1'b1);
    settle();
    write_mode(MODE_SHA384);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h3C, 1'b1);

    // Random messages over three idle profiles
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 60 : 0;
      out_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 16 : 0;
      while (rand_bytes < 45 * (phase + 1)) begin
        if ($urandom_range(3) == 0) begin
          settle();
          write_mode(hash_mode_t'($urandom_range(3)));
        end
        len = pick_length(book.mode);
        // Switch modes mid-message only once every buffer entry holds a byte
        split = (book.store_full() && len > 1 && $urandom_range(5) == 0) ?
                $urandom_range(1, len - 1) : 0;
        for (int unsigned k = 0; k < len; k++) begin
          if (split != 0 && k == split) begin
            settle();
            write_mode(hash_mode_t'($urandom_range(3)));
          end
          send_byte(8'($urandom_range(255)), k == len - 1);
        end
        rand_bytes += len;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Ran %0d messages (%0d random bytes) and checked %0d words", book.messages,
             rand_bytes, book.words_checked);
    $display("covering all four hash modes, padding overflow, full blocks and mode switches");
    if (book.errors == 0) begin
      $display("sha2_message_padder_unit_tb passed");
    end else begin
      $display("sha2_message_padder_unit_tb failed");
    end
    $finish;
  end

endmodule
